/* rtl/sha256_message_hash_core_macros.svh */
// assertion macros for the sha-256 message hash core
`ifndef SHA256_MESSAGE_HASH_CORE_MACROS_SVH
`define SHA256_MESSAGE_HASH_CORE_MACROS_SVH

// implication checked on every clock outside reset
`define SHA_ASSERT_IMP(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("%m: check failed");

// implication checked in the cycle after the condition
`define SHA_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("%m: check failed");

`endif

/* rtl/sha256_pkg.sv */
// shared types, constants and round functions for the sha-256 core
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } sha_state_t;

  localparam logic [7:0] PAD_MARKER = 8'h80;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage
`default_nettype wire

/* rtl/sha256_message_hash_core.sv */
// sha-256 message hash core: byte input, block memory, iterative compression
//
//   channel | direction | payload
//   in_     | input     | msg_byte, byte_present, end_of_message
//   out_    | output    | digest_word, word_index, digest_last
//
// a byte is taken on each accepted input while the block is filling. the
// 64th byte of a block starts compression: the word memory is read into the
// schedule window, then 64 rounds (one schedule word per cycle) and an add
// step. an end request pads into one or two blocks, then shows eight digest
// words, one per accepted output. reset loads the iv into the chain, clears
// counts and control but never the block memory; output stalls hold the word.
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_message_hash_core_macros.svh"
module sha256_message_hash_core
  import sha256_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_msg_byte,
  input  wire logic        in_byte_present,
  input  wire logic        in_end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_digest_last
);

  // block memory, 16 big-endian words, byte-write
  logic [31:0] blk_mem [16];
  logic [31:0] blk_rd_r;
  logic        mem_we;
  logic [3:0]  mem_waddr;
  logic [3:0]  mem_wbe;
  logic [31:0] mem_wdata;
  logic [3:0]  mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int b = 0; b < 4; b++) begin
        if (mem_wbe[b]) begin
          blk_mem[mem_waddr][b*8 +: 8] <= mem_wdata[b*8 +: 8];
        end
      end
    end
    blk_rd_r <= blk_mem[mem_raddr];
  end

  sha_state_t  state_r, state_nxt;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [63:0] total_r, total_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        fin_r, fin_nxt;     // finishing the message
  logic        pad2_r, pad2_nxt;   // a length-only block still follows
  logic        pend_r, pend_nxt;   // end came with a block's last byte
  logic [2:0]  oidx_r, oidx_nxt;

  logic        in_fire;
  logic [31:0] w_new, w_cur, t1, t2;
  logic [5:0]  rnd;

  assign in_fire = in_valid && in_ready;
  assign rnd     = cnt_r[5:0];

  // schedule word and round datapath
  always_comb begin
    w_new = small_s1(w_r[14]) + w_r[9] + small_s0(w_r[1]) + w_r[0];
    w_cur = (cnt_r < 7'd16) ? w_r[rnd[3:0]] : w_new;
    t1 = v_r[7] + big_s1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + ROUND_K[rnd] + w_cur;
    t2 = big_s0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      total_r <= '0;
      fill_r  <= '0;
      cnt_r   <= '0;
      fin_r   <= 1'b0;
      pad2_r  <= 1'b0;
      pend_r  <= 1'b0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      fill_r  <= fill_nxt;
      cnt_r   <= cnt_nxt;
      fin_r   <= fin_nxt;
      pad2_r  <= pad2_nxt;
      pend_r  <= pend_nxt;
      oidx_r  <= oidx_nxt;
    end
  end

  // chain value, round variables and schedule window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) h_r[i] <= IV[i];
    end else begin
      if (state_r == ST_LOAD && cnt_r != 7'd0) begin
        // memory word for index cnt-1 arrives; window fills in order
        w_r[cnt_r[3:0] - 4'd1] <= blk_rd_r;
        if (cnt_r == 7'd1) begin
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        end
      end
      if (state_r == ST_ROUND) begin
        if (cnt_r >= 7'd16) begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= w_new;
        end
        v_r[7] <= v_r[6];
        v_r[6] <= v_r[5];
        v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2];
        v_r[2] <= v_r[1];
        v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
      end
      if (state_r == ST_ADD) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
      if (state_r == ST_OUT && out_ready && oidx_r == 3'd7) begin
        for (int i = 0; i < 8; i++) h_r[i] <= IV[i];
      end
    end
  end

  // window index during rounds 0..15 uses w_r[rnd], which needs no shift since
  // the window is shifted only from round 16 on: w_r[k] = block word k, and
  // afterwards w_r[0] is always schedule word t-16

  always_comb begin
    state_nxt = state_r;
    total_nxt = total_r;
    fill_nxt  = fill_r;
    cnt_nxt   = cnt_r;
    fin_nxt   = fin_r;
    pad2_nxt  = pad2_r;
    pend_nxt  = pend_r;
    oidx_nxt  = oidx_r;
    in_ready  = (state_r == ST_IDLE);
    mem_we    = 1'b0;
    mem_waddr = fill_r[5:2];
    mem_wbe   = 4'b1000 >> fill_r[1:0];
    mem_wdata = {4{in_msg_byte}};
    mem_raddr = cnt_r[3:0];
    out_valid = (state_r == ST_OUT);
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_byte_present) begin
            mem_we    = 1'b1;
            total_nxt = total_r + 64'd1;
            fill_nxt  = fill_r + 6'd1;
          end
          fin_nxt = in_end_of_message;
          cnt_nxt = '0;
          if (in_byte_present && fill_r == 6'd63) begin
            // the full data block goes first, padding after it
            fin_nxt   = 1'b0;
            pend_nxt  = in_end_of_message;
            state_nxt = ST_LOAD;
          end else if (in_end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // one write per cycle: marker word, zero fill, then length words
        mem_we = 1'b1;
        if (cnt_r == 7'd0) begin
          mem_waddr = fill_r[5:2];
          unique case (fill_r[1:0])
            2'd0: begin mem_wbe = 4'b1111; mem_wdata = {PAD_MARKER, 24'd0}; end
            2'd1: begin mem_wbe = 4'b0111; mem_wdata = {8'd0, PAD_MARKER, 16'd0}; end
            2'd2: begin mem_wbe = 4'b0011; mem_wdata = {16'd0, PAD_MARKER, 8'd0}; end
            default: begin mem_wbe = 4'b0001; mem_wdata = {24'd0, PAD_MARKER}; end
          endcase
          pad2_nxt = (fill_r >= 6'd56);
          if (fill_r[5:2] == 4'd15) begin
            // marker in the last word: nothing left to zero
            cnt_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            cnt_nxt = {3'd0, fill_r[5:2]} + 7'd1;
          end
        end else begin
          mem_waddr = cnt_r[3:0];
          mem_wbe   = 4'b1111;
          mem_wdata = '0;
          if (!pad2_r && cnt_r == 7'd14) mem_wdata = {total_r[60:29]};
          if (!pad2_r && cnt_r == 7'd15) mem_wdata = {total_r[28:0], 3'd0};
          if (cnt_r[3:0] == 4'd15) begin
            cnt_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            cnt_nxt = cnt_r + 7'd1;
          end
        end
      end
      ST_LOAD: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd16) begin
          cnt_nxt   = '0;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          cnt_nxt   = '0;
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        fill_nxt = '0;
        if (!fin_r) begin
          if (pend_r) begin
            pend_nxt  = 1'b0;
            fin_nxt   = 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_PAD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else if (pad2_r) begin
          // second block: zeros up to the length, word 0 cleared here
          mem_we    = 1'b1;
          mem_waddr = 4'd0;
          mem_wbe   = 4'b1111;
          mem_wdata = '0;
          pad2_nxt  = 1'b0;
          cnt_nxt   = 7'd1;
          state_nxt = ST_PAD;
        end else begin
          oidx_nxt  = '0;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            total_nxt = '0;
            fill_nxt  = '0;
            fin_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_digest_word = h_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_digest_last = (oidx_r == 3'd7);

  `SHA_ASSERT_IMP(a_ready_only_idle, clk, rst_n, in_ready, !out_valid)
  `SHA_ASSERT_NEXT(a_last_to_idle, clk, rst_n, out_valid && out_ready && out_digest_last,
    state_r == ST_IDLE && fill_r == 6'd0)
  `SHA_ASSERT_NEXT(a_round_count, clk, rst_n, state_r == ST_ROUND && cnt_r != 7'd63,
    state_r == ST_ROUND && cnt_r == $past(cnt_r) + 7'd1)

endmodule
`default_nettype wire
